// File: design/itp_pkg.sv
// Package for the infix to postfix converter: sizes, token and error codes, stack entry.
package itp_pkg;

  // Stack and code sizes
  localparam int STACK_DEPTH = 16;
  localparam int CODE_WIDTH  = 16;
  localparam int CODE_W      = (CODE_WIDTH < 16) ? CODE_WIDTH : 16;
  localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Token kinds
  localparam logic [2:0] KIND_NUMBER = 3'd0;
  localparam logic [2:0] KIND_OPEN   = 3'd1;
  localparam logic [2:0] KIND_CLOSE  = 3'd2;
  localparam logic [2:0] KIND_BINOP  = 3'd3;
  localparam logic [2:0] KIND_FUNC   = 3'd4;
  localparam logic [2:0] KIND_UNOP   = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_CLOSE    = 2'd2;
  localparam logic [1:0] ERR_OPEN     = 2'd3;

  // One operator stack entry
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [2:0]        kind;
    logic [3:0]        prec;
    logic              rassoc;
  } stack_entry_t;

  // One result word before it is released
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [2:0]        kind;
    logic [1:0]        err;
  } result_t;

endpackage

// File: design/infix_to_postfix_converter_top.sv
// Shunting yard infix to postfix converter with the operator stack in a synchronous RAM.
//
//  channel  direction  word fields
//  -------  ---------  -------------------------------------------------------------
//  in       input      token_code, token_kind, precedence, right_assoc, end_of_expression
//  out      output     out_code, out_kind, last_of_run, expression_done, error_code
//
// A token passes an accept step in ST_IDLE, one evaluate step per pop plus one for its
// push or pass in ST_EVAL, and a closing step in ST_FIN.
// End of expression adds a stack re-read in ST_RD, one evaluate step per flushed entry
// and one more evaluate step that finds the stack empty.
// The single registered read port of the stack RAM sets one pop per cycle unless out_stall holds it.
// rst (synchronous) empties the stack and clears all control state; RAM is not cleared.
// out_stall holds the sequencer whenever a word must move out; in_stall is high while busy.
module infix_to_postfix_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] token_code,
  input  logic [2:0]  token_kind,
  input  logic [3:0]  precedence,
  input  logic        right_assoc,
  input  logic        end_of_expression,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code,
  output logic [2:0]  out_kind,
  output logic        last_of_run,
  output logic        expression_done,
  output logic [1:0]  error_code
);
  import itp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state, state_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic              flushing;

  // Latched token
  logic [CODE_W-1:0] tok_code;
  logic [2:0]        tok_kind;
  logic [3:0]        tok_prec;
  logic              tok_rassoc;
  logic              tok_eoe;

  // Stack RAM
  stack_entry_t      stack_mem [STACK_DEPTH];
  stack_entry_t      rd_q;
  stack_entry_t      wr_data;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [SP_W-1:0]   sp_m1, sp_m2;

  // Pending result, held until the next one shows whether it closes the run
  result_t           pend;
  logic              pend_valid;

  // Evaluate decisions
  logic              do_emit, do_pop, do_push, main_done, flush_done, go;
  result_t           emit_word;
  logic              top_valid, stack_full, top_pops, out_free, emit_ok, accept;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != ST_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign emit_ok    = !pend_valid || out_free;
  assign top_valid  = (sp != '0);
  assign stack_full = (sp == SP_W'(STACK_DEPTH));
  assign sp_m1      = sp - SP_W'(1);
  assign sp_m2      = sp - SP_W'(2);
  assign top_pops   = top_valid && (rd_q.kind != KIND_OPEN) &&
                      ((rd_q.prec > tok_prec) || ((rd_q.prec == tok_prec) && !tok_rassoc));

  // Evaluate one step against the stack top
  always_comb begin
    do_emit    = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    main_done  = 1'b0;
    flush_done = 1'b0;
    emit_word  = '{code: tok_code, kind: tok_kind, err: ERR_OK};
    if (!flushing) begin
      unique case (tok_kind)
        KIND_NUMBER: begin
          do_emit   = 1'b1;
          main_done = 1'b1;
        end
        KIND_OPEN: begin
          main_done = 1'b1;
          if (stack_full) begin
            do_emit       = 1'b1;
            emit_word.err = ERR_OVERFLOW;
          end else begin
            do_push = 1'b1;
          end
        end
        KIND_CLOSE: begin
          if (!top_valid) begin
            do_emit       = 1'b1;
            emit_word.err = ERR_CLOSE;
            main_done     = 1'b1;
          end else if (rd_q.kind == KIND_OPEN) begin
            do_pop    = 1'b1;
            main_done = 1'b1;
          end else begin
            do_emit   = 1'b1;
            do_pop    = 1'b1;
            emit_word = '{code: rd_q.code, kind: rd_q.kind, err: ERR_OK};
          end
        end
        KIND_BINOP, KIND_FUNC, KIND_UNOP: begin
          if (top_pops) begin
            do_emit   = 1'b1;
            do_pop    = 1'b1;
            emit_word = '{code: rd_q.code, kind: rd_q.kind, err: ERR_OK};
          end else if (stack_full) begin
            do_emit       = 1'b1;
            emit_word.err = ERR_OVERFLOW;
            main_done     = 1'b1;
          end else begin
            do_push   = 1'b1;
            main_done = 1'b1;
          end
        end
        default: main_done = 1'b1;
      endcase
    end else if (!top_valid) begin
      flush_done = 1'b1;
    end else begin
      do_emit   = 1'b1;
      do_pop    = 1'b1;
      emit_word = '{code: rd_q.code, kind: rd_q.kind,
                    err: (rd_q.kind == KIND_OPEN) ? ERR_OPEN : ERR_OK};
    end
    go = !do_emit || emit_ok;
  end

  // Sequencer next state, stack pointer and RAM port control
  always_comb begin
    state_next = state;
    sp_next    = sp;
    rd_en      = 1'b0;
    rd_addr    = sp_m1[ADDR_W-1:0];
    wr_en      = 1'b0;
    wr_data    = '{code: tok_code, kind: tok_kind, prec: tok_prec, rassoc: tok_rassoc};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          rd_en      = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_RD: begin
        rd_en      = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (go) begin
          if (do_pop) begin
            sp_next = sp_m1;
            rd_en   = 1'b1;
            rd_addr = sp_m2[ADDR_W-1:0];
          end
          if (do_push) begin
            sp_next = sp + SP_W'(1);
            wr_en   = 1'b1;
          end
          if (main_done) begin
            state_next = tok_eoe ? ST_RD : ST_FIN;
          end else if (flush_done) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Stack RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[sp[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= stack_mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sp       <= '0;
      flushing <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      if (accept) begin
        flushing <= 1'b0;
      end else if (state == ST_EVAL && go && main_done && tok_eoe) begin
        flushing <= 1'b1;
      end
    end
  end

  // Token latch
  always_ff @(posedge clk) begin
    if (accept) begin
      tok_code   <= token_code[CODE_W-1:0];
      tok_kind   <= token_kind;
      tok_prec   <= precedence;
      tok_rassoc <= right_assoc;
      tok_eoe    <= end_of_expression;
    end
  end

  // Pending word and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_EVAL && do_emit && go) begin
        if (pend_valid) begin
          out_valid       <= 1'b1;
          out_code        <= 16'(pend.code);
          out_kind        <= pend.kind;
          error_code      <= pend.err;
          last_of_run     <= 1'b0;
          expression_done <= 1'b0;
        end else if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
        pend       <= emit_word;
        pend_valid <= 1'b1;
      end else if (state == ST_FIN && pend_valid && out_free) begin
        out_valid       <= 1'b1;
        out_code        <= 16'(pend.code);
        out_kind        <= pend.kind;
        error_code      <= pend.err;
        last_of_run     <= 1'b1;
        expression_done <= tok_eoe;
        pend_valid      <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_no_pend_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !pend_valid)
    else $error("token accepted with a result still pending");

  a_sp_step: assert property (@(posedge clk) disable iff (rst)
    $past(state) != ST_EVAL |-> $stable(sp))
    else $error("stack pointer moved outside evaluate");

  a_open_err_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == ERR_OPEN) |-> out_kind == KIND_OPEN)
    else $error("leftover bracket error on a non-bracket word");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && expression_done) |-> last_of_run)
    else $error("expression done without end of run");

endmodule

// File: tb/sv/infix_to_postfix_converter_top_test.sv
// Self-checking testbench for the infix to postfix converter: directed table, then random expressions.
`timescale 1ns / 100ps

module infix_to_postfix_converter_top_test;
  import itp_pkg::*;

  // Kinds outside the token set; the block ignores them
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam int RANDOM_TOKENS = 52;
  // Worst case between two accepts: the longest sender gap, then a 17-word run
  // under a heavy random stall. IDLE_LIMIT leaves a wide margin.
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [15:0] code;
    logic [2:0]  kind;
    logic [3:0]  prec;
    logic        ra;
    logic        eoe;
  } token_t;

  typedef struct packed {
    logic [15:0] code;
    logic [2:0]  kind;
    logic        last;
    logic        done;
    logic [1:0]  err;
  } postfix_word_t;

  // One line of the directed table; reps repeats the token
  typedef struct packed {
    token_t        tok;
    logic [4:0]    reps;
    logic          typed;
    postfix_word_t want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] token_code;
  logic [2:0]  token_kind;
  logic [3:0]  precedence;
  logic        right_assoc;
  logic        end_of_expression;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_code;
  logic [2:0]  out_kind;
  logic        last_of_run;
  logic        expression_done;
  logic [1:0]  error_code;

  infix_to_postfix_converter_top u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .token_code        (token_code),
    .token_kind        (token_kind),
    .precedence        (precedence),
    .right_assoc       (right_assoc),
    .end_of_expression (end_of_expression),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code          (out_code),
    .out_kind          (out_kind),
    .last_of_run       (last_of_run),
    .expression_done   (expression_done),
    .error_code        (error_code)
  );

  // Predictor state: our own copy of the operator stack
  stack_entry_t  held_ops [STACK_DEPTH];
  int            held_count;
  postfix_word_t fresh_words [$];
  postfix_word_t postfix_due [$];
  plan_row_t     plan [$];

  int mismatches;
  int words_checked;
  int tokens_sent;
  int exprs_done;
  int err_seen [4];
  int burst_left;
  int idle_cycles;
  int stall_cyc;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic flag(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Predictor helpers
  function automatic void emit_word(input logic [15:0] code, input logic [2:0] kind,
                                    input logic [1:0] err);
    postfix_word_t w;
    w.code = code;
    w.kind = kind;
    w.last = 1'b0;
    w.done = 1'b0;
    w.err  = err;
    fresh_words = {fresh_words, w};
  endfunction

  function automatic void pop_op();
    held_count--;
    emit_word(held_ops[held_count].code, held_ops[held_count].kind, ERR_OK);
  endfunction

  function automatic void push_op(input token_t t);
    if (held_count >= STACK_DEPTH) begin
      emit_word(t.code, t.kind, ERR_OVERFLOW);
    end else begin
      held_ops[held_count] = '{code: t.code, kind: t.kind, prec: t.prec, rassoc: t.ra};
      held_count++;
    end
  endfunction

  // Shunting yard step: fills fresh_words with the words one token causes
  function automatic void shunt_token(input token_t t);
    logic          matched;
    fresh_words.delete();
    case (t.kind)
      KIND_NUMBER: emit_word(t.code, t.kind, ERR_OK);
      KIND_OPEN:   push_op(t);
      KIND_CLOSE: begin
        matched = 1'b0;
        while (held_count > 0 && !matched) begin
          if (held_ops[held_count-1].kind == KIND_OPEN) begin
            held_count--;
            matched = 1'b1;
          end else begin
            pop_op();
          end
        end
        if (!matched) emit_word(t.code, t.kind, ERR_CLOSE);
      end
      KIND_BINOP, KIND_FUNC, KIND_UNOP: begin
        // open bracket is a barrier; pop tighter ops, or equal ones for left assoc
        while (held_count > 0 && held_ops[held_count-1].kind != KIND_OPEN &&
               (held_ops[held_count-1].prec > t.prec ||
                (held_ops[held_count-1].prec == t.prec && !t.ra)))
          pop_op();
        push_op(t);
      end
      default: ;
    endcase
    // flush; leftover open brackets come out as errors
    if (t.eoe) begin
      while (held_count > 0) begin
        if (held_ops[held_count-1].kind == KIND_OPEN) begin
          held_count--;
          emit_word(held_ops[held_count].code, held_ops[held_count].kind, ERR_OPEN);
        end else begin
          pop_op();
        end
      end
    end
    if (fresh_words.size() > 0) begin
      fresh_words[fresh_words.size()-1].last = 1'b1;
      fresh_words[fresh_words.size()-1].done = t.eoe;
    end
  endfunction

  function automatic void add_row(input logic [15:0] code, input logic [2:0] kind,
                                  input logic [3:0] prec, input logic ra, input logic eoe,
                                  input int reps, input logic typed, input logic [1:0] err);
    plan_row_t p;
    p.tok   = '{code: code, kind: kind, prec: prec, ra: ra, eoe: eoe};
    p.reps  = reps[4:0];
    p.typed = typed;
    p.want  = '{code: code, kind: kind, last: 1'b1, done: eoe, err: err};
    plan = {plan, p};
  endfunction

  // Send one word in bursts with random gaps; predict on accept
  task automatic drive_token(input token_t t, input logic typed, input postfix_word_t want);
    int gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid          = 1'b1;
    token_code        = t.code;
    token_kind        = t.kind;
    precedence        = t.prec;
    right_assoc       = t.ra;
    end_of_expression = t.eoe;
    do @(posedge clk); while (in_stall);
    shunt_token(t);
    if (typed) begin
      postfix_due = {postfix_due, want};
    end else begin
      postfix_due = {postfix_due, fresh_words};
    end
    tokens_sent++;
    @(negedge clk);
  endtask

  // Receiver stall pattern: cycles through calm, light, heavy and periodic stretches
  always @(negedge clk) begin
    stall_cyc++;
    case ((stall_cyc / 97) % 4)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      2: out_stall = ($urandom_range(0, 9) < 6);
      default: out_stall = ((stall_cyc % 5) < 2);
    endcase
  end

  // Output check against the oldest expected word
  always @(posedge clk) begin
    postfix_word_t w;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (postfix_due.size() == 0) begin
        flag("unexpected word, code", int'(out_code), 0);
      end else begin
        w = postfix_due.pop_front();
        if (out_code !== w.code) flag("out_code", int'(out_code), int'(w.code));
        if (out_kind !== w.kind) flag("out_kind", int'(out_kind), int'(w.kind));
        if (last_of_run !== w.last) flag("last_of_run", int'(last_of_run), int'(w.last));
        if (expression_done !== w.done)
          flag("expression_done", int'(expression_done), int'(w.done));
        if (error_code !== w.err) flag("error_code", int'(error_code), int'(w.err));
        words_checked++;
        if (w.done) exprs_done++;
        err_seen[w.err]++;
      end
    end
  end

  // Watchdog: too long without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    token_t        t;
    postfix_word_t none;
    int            counted;
    int            r;
    int            open_depth;
    int            expr_len;
    int            target;
    logic          need_operand;
    logic          paused;

    rst               = 1'b1;
    in_valid          = 1'b0;
    token_code        = '0;
    token_kind        = KIND_NUMBER;
    precedence        = '0;
    right_assoc       = 1'b0;
    end_of_expression = 1'b0;
    none              = '0;
    mismatches = 0; words_checked = 0; tokens_sent = 0; exprs_done = 0;
    burst_left = 0;
    err_seen = '{default: 0};
    held_count = 0;

    // Directed table: extremes, all kinds, every error, silent end, deepest runs
    add_row(16'hFFFF, KIND_NUMBER, 4'd15, 1'b1, 1'b0, 1, 1'b1, ERR_OK);
    add_row(16'h0000, KIND_CLOSE,  4'd0,  1'b0, 1'b0, 1, 1'b1, ERR_CLOSE);
    add_row(16'h0000, KIND_NUMBER, 4'd0,  1'b0, 1'b1, 1, 1'b1, ERR_OK);
    add_row(16'h1111, KIND_OPEN,   4'd0,  1'b0, 1'b1, 1, 1'b1, ERR_OPEN);
    // 1 - 2 + 3 * (4 ^ 5 ^ 6) / f ~ 7
    add_row(16'h0001, KIND_NUMBER, 4'd0,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h002D, KIND_BINOP,  4'd2,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0002, KIND_NUMBER, 4'd0,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h002B, KIND_BINOP,  4'd2,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0003, KIND_NUMBER, 4'd0,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h002A, KIND_BINOP,  4'd3,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0028, KIND_OPEN,   4'd0,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0004, KIND_NUMBER, 4'd0,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h005E, KIND_BINOP,  4'd15, 1'b1, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0005, KIND_NUMBER, 4'd0,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h015E, KIND_BINOP,  4'd15, 1'b1, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0006, KIND_NUMBER, 4'd0,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0029, KIND_CLOSE,  4'd0,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h002F, KIND_BINOP,  4'd3,  1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0073, KIND_FUNC,   4'd14, 1'b0, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h007E, KIND_UNOP,   4'd14, 1'b1, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h0007, KIND_NUMBER, 4'd0,  1'b0, 1'b1, 1, 1'b0, ERR_OK);
    // ignored kinds; the second ends an empty expression with no word
    add_row(16'hAAAA, KIND_SPARE6, 4'd5,  1'b1, 1'b0, 1, 1'b0, ERR_OK);
    add_row(16'h5555, KIND_SPARE7, 4'd10, 1'b0, 1'b1, 1, 1'b0, ERR_OK);
    // fill the stack with brackets, overflow, then flush all of them as errors
    add_row(16'h8000, KIND_OPEN,   4'd15, 1'b1, 1'b0, 16, 1'b0, ERR_OK);
    add_row(16'h8001, KIND_OPEN,   4'd0,  1'b0, 1'b0, 1, 1'b1, ERR_OVERFLOW);
    add_row(16'h7FFF, KIND_NUMBER, 4'd0,  1'b0, 1'b1, 1, 1'b0, ERR_OK);
    // full stack of right-assoc ops, then an unmatched close pops them all
    add_row(16'hC000, KIND_BINOP,  4'd15, 1'b1, 1'b0, 16, 1'b0, ERR_OK);
    add_row(16'h0029, KIND_CLOSE,  4'd0,  1'b0, 1'b1, 1, 1'b0, ERR_OK);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i])
      repeat (plan[i].reps) drive_token(plan[i].tok, plan[i].typed, plan[i].want);

    // Random expressions: mostly well formed, some noise and broken brackets
    counted = 0; open_depth = 0; expr_len = 0; target = 4;
    need_operand = 1'b1; paused = 1'b0;
    while (counted < RANDOM_TOKENS) begin
      t.code = 16'($urandom_range(0, 16'hFFFF));
      t.prec = 4'($urandom_range(0, 15));
      t.ra   = 1'($urandom_range(0, 1));
      t.eoe  = 1'b0;
      if ($urandom_range(0, 99) < 12) begin
        t.kind = 3'($urandom_range(0, 7));
        t.eoe  = ($urandom_range(0, 3) == 0);
      end else if (need_operand) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          t.kind = KIND_NUMBER;
          need_operand = 1'b0;
          // end here; sometimes with brackets left open
          if (expr_len >= target && (open_depth == 0 || $urandom_range(0, 3) == 0))
            t.eoe = 1'b1;
        end else if (r < 8) begin
          t.kind = KIND_OPEN;
          open_depth++;
        end else begin
          t.kind = (r == 8) ? KIND_FUNC : KIND_UNOP;
        end
      end else if (open_depth > 0 && $urandom_range(0, 2) == 0) begin
        t.kind = KIND_CLOSE;
        open_depth--;
        t.eoe = (expr_len >= target && open_depth == 0);
      end else if ($urandom_range(0, 19) == 0) begin
        t.kind = KIND_CLOSE;
      end else begin
        t.kind = KIND_BINOP;
        need_operand = 1'b1;
      end
      expr_len++;
      if (t.eoe) begin
        need_operand = 1'b1;
        open_depth = 0;
        expr_len = 0;
        target = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      end
      drive_token(t, 1'b0, none);
      if (t.kind <= KIND_UNOP) counted++;
      // hold off once until the block has drained
      if (!paused && counted == RANDOM_TOKENS / 2) begin
        paused = 1'b1;
        in_valid = 1'b0;
        while (postfix_due.size() != 0) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    while (postfix_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (postfix_due.size() != 0) flag("words still due", postfix_due.size(), 0);

    $display("Sent %0d tokens, checked %0d postfix words over %0d finished expressions",
             tokens_sent, words_checked, exprs_done);
    $display("Error words seen: overflow %0d, unmatched close %0d, leftover open %0d",
             err_seen[ERR_OVERFLOW], err_seen[ERR_CLOSE], err_seen[ERR_OPEN]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
